// File: design/tmh_pkg.sv
// ----------------------------------------------------------------------------
// tmh_pkg
// Shared types and constants of the temperature monitor: field widths,
// conversion constants, configuration register indexes and the queue item.
// ----------------------------------------------------------------------------
package tmh_pkg;

  // field widths
  localparam int unsigned AdcW    = 16;
  localparam int unsigned TempW   = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 12;

  // converter scaling: temp = TempMin + (count*Gain + RoundAdd) / AdcMax
  localparam logic [11:0] AdcMax   = 12'd4095;
  localparam int unsigned ScaleW   = 23;
  localparam logic [ScaleW-1:0] RoundAdd = 23'd2047;
  localparam logic signed [TempW-1:0] TempMin = -12'sd400;
  localparam logic signed [TempW-1:0] TempMax = 12'sd1250;

  // threshold reset values
  localparam logic signed [CfgW-1:0] ThrHighRst = 12'sd1000;
  localparam logic signed [CfgW-1:0] ThrLowRst  = 12'sd900;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgThrHigh = 2'd0,
    CfgThrLow  = 2'd1
  } tmh_cfg_idx_e;

  // converted sample on its way from front to back
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic                    win_full;
  } tmh_item_t;

endpackage

// File: design/tmh_front.sv
// ----------------------------------------------------------------------------
// tmh_front
// Accepts converter counts, converts them to tenths of a degree and tags
// each sample with whether the averaging window is already full.
// ----------------------------------------------------------------------------
module tmh_front #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tmh_pkg::AdcW-1:0]   adc_count_i,
  input  logic                       full_i,
  output logic                       push_o,
  output tmh_pkg::tmh_item_t         item_o
);
  import tmh_pkg::*;

  localparam int unsigned FillW = $clog2(WINDOW_LEN + 1);

  logic                accept;
  logic [11:0]         cnt_clamp;
  logic [ScaleW-1:0]   cx;
  logic [ScaleW-1:0]   x_d, x_q;
  logic                v1_q;
  logic                tag_q;
  logic [FillW-1:0]    fill_q;
  logic [35:0]         est;
  logic [10:0]         q0;
  logic [ScaleW-1:0]   q0x;
  logic [ScaleW-1:0]   rem;
  logic [10:0]         quo;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !v1_q || !full_i;
  assign push_o     = v1_q && !full_i;

  // clamp and scale: count*1650 as shifts, plus rounding term
  assign cnt_clamp = (adc_count_i > AdcW'(AdcMax)) ? AdcMax : adc_count_i[11:0];
  assign cx        = ScaleW'(cnt_clamp);
  assign x_d       = (cx << 10) + (cx << 9) + (cx << 6) + (cx << 5) + (cx << 4)
                   + (cx << 1) + RoundAdd;

  // stage register and fill tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (push_o) begin
        v1_q <= 1'b0;
      end
      if (accept && (fill_q != FillW'(WINDOW_LEN))) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= x_d;
      tag_q <= (fill_q == FillW'(WINDOW_LEN));
    end
  end

  // divide by 4095: estimate x*4097/2^24 is exact or one low, one correction
  assign est = {1'b0, x_q, 12'b0} + 36'(x_q);
  assign q0  = est[34:24];
  assign q0x = {q0, 12'b0} - ScaleW'(q0);
  assign rem = x_q - q0x;
  assign quo = q0 + 11'((rem >= ScaleW'(AdcMax)) ? 1 : 0);

  // quotient stays within 0..1650, so the result needs no range clamp
  assign item_o.temp     = signed'({1'b0, quo}) + TempMin;
  assign item_o.win_full = tag_q;

endmodule

// File: design/tmh_queue.sv
// ----------------------------------------------------------------------------
// tmh_queue
// Two-entry queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module tmh_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tmh_pkg::tmh_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output tmh_pkg::tmh_item_t item_o
);
  import tmh_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tmh_item_t        mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule

// File: design/tmh_back.sv
// ----------------------------------------------------------------------------
// tmh_back
// Sample ring with running sum, average by reciprocal multiply, hysteresis
// comparator and the result register. Holds the threshold registers.
// ----------------------------------------------------------------------------
module tmh_back #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tmh_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tmh_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic                              q_valid_i,
  input  tmh_pkg::tmh_item_t                q_item_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tmh_pkg::TempW-1:0]  temperature_o,
  output logic                              filtered_valid_o,
  output logic signed [tmh_pkg::TempW-1:0]  filtered_temperature_o,
  output logic                              unsafe_o
);
  import tmh_pkg::*;

  localparam int unsigned SlotW = $clog2(WINDOW_LEN);
  localparam int unsigned SumW  = $clog2(WINDOW_LEN * 1250 + 1) + 1;
  localparam int unsigned AbsW  = SumW - 1;
  localparam int unsigned RecK  = AbsW + $clog2(WINDOW_LEN) + 1;
  localparam longint unsigned RecL = (64'd1 << RecK) / WINDOW_LEN + 1;
  localparam logic [RecK:0] RecM = RecL[RecK:0];
  localparam int unsigned ProdW = AbsW + RecK + 1;

  logic signed [CfgW-1:0]  thr_high_q, thr_low_q;
  logic                    advance;
  logic signed [TempW-1:0] ring_q [WINDOW_LEN];
  logic [SlotW-1:0]        slot_q;
  logic signed [SumW-1:0]  sum_q, sum_d, old_ext, new_ext;

  logic                    a_v_q, a_full_q;
  logic signed [TempW-1:0] a_temp_q;
  logic signed [SumW-1:0]  a_sum_q;

  logic                    b_v_q, b_full_q;
  logic signed [TempW-1:0] b_temp_q, b_avg_q, avg_d;
  logic                    neg;
  logic [AbsW-1:0]         mag;
  logic [ProdW-1:0]        prod;
  logic [TempW-1:0]        qmag;

  logic                    unsafe_q, unsafe_d;
  logic                    out_v_q, fv_q;
  logic signed [TempW-1:0] temp_q, favg_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_high_q <= ThrHighRst;
      thr_low_q  <= ThrLowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgThrHigh: thr_high_q <= cfg_wdata_i;
        CfgThrLow:  thr_low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the result register is free
  assign advance = !out_v_q || out_ready_i;
  assign pop_o   = advance && q_valid_i;

  // ring update and running sum
  assign old_ext = {{(SumW-TempW){ring_q[slot_q][TempW-1]}}, ring_q[slot_q]};
  assign new_ext = {{(SumW-TempW){q_item_i.temp[TempW-1]}}, q_item_i.temp};
  assign sum_d   = sum_q + new_ext - (q_item_i.win_full ? old_ext : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      sum_q  <= '0;
    end else if (pop_o) begin
      slot_q <= (slot_q == SlotW'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ring_q[slot_q] <= q_item_i.temp;
    end
  end

  // average: magnitude times reciprocal, truncated toward zero
  assign neg   = a_sum_q[SumW-1];
  assign mag   = neg ? AbsW'(-a_sum_q) : AbsW'(a_sum_q);
  assign prod  = ProdW'(mag) * ProdW'(RecM);
  assign qmag  = prod[RecK +: TempW];
  assign avg_d = neg ? -signed'(qmag) : signed'(qmag);

  // hysteresis on the filtered value
  always_comb begin
    unsafe_d = unsafe_q;
    if (b_full_q) begin
      if (!unsafe_q) begin
        unsafe_d = (b_avg_q >= thr_high_q);
      end else begin
        unsafe_d = !(b_avg_q <= thr_low_q);
      end
    end
  end

  // pipeline valid bits and hysteresis state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q    <= 1'b0;
      b_v_q    <= 1'b0;
      out_v_q  <= 1'b0;
      unsafe_q <= 1'b0;
    end else if (advance) begin
      a_v_q   <= pop_o;
      b_v_q   <= a_v_q;
      out_v_q <= b_v_q;
      if (b_v_q) begin
        unsafe_q <= unsafe_d;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (pop_o) begin
        a_temp_q <= q_item_i.temp;
        a_full_q <= q_item_i.win_full;
        a_sum_q  <= sum_d;
      end
      if (a_v_q) begin
        b_temp_q <= a_temp_q;
        b_full_q <= a_full_q;
        b_avg_q  <= avg_d;
      end
      if (b_v_q) begin
        temp_q <= b_temp_q;
        fv_q   <= b_full_q;
        favg_q <= b_full_q ? b_avg_q : '0;
      end
    end
  end

  assign out_valid_o            = out_v_q;
  assign temperature_o          = temp_q;
  assign filtered_valid_o       = fv_q;
  assign filtered_temperature_o = favg_q;
  assign unsafe_o               = unsafe_q;

  a_fill_keeps_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && b_v_q && !b_full_q) |=> $stable(unsafe_q))
    else $error("hysteresis flag moved during window fill");

  a_unfiltered_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !fv_q) |-> (favg_q == '0))
    else $error("filtered value not zero while window fills");

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && fv_q) |-> ((favg_q >= TempMin) && (favg_q <= TempMax)))
    else $error("filtered value out of range");

endmodule

// File: design/temperature_monitor_with_hysteresis.sv
// ----------------------------------------------------------------------------
// temperature_monitor_with_hysteresis
// Converter count to temperature, moving average and hysteresis flag.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   input    | in_valid_i / in_ready_o    | adc_count_i
//   result   | out_valid_o / out_ready_i  | temperature_o, filtered_valid_o,
//            |                            | filtered_temperature_o, unsafe_o
//   config   | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while out_ready_i stays high. From acceptance
// to result a sample passes one scaling stage, the divide-by-4095 step into a
// two-entry queue, then ring update, average multiply and the result register.
// The running-sum update on the ring sets the one-per-cycle figure.
// Reset clears control state and loads threshold defaults; no clearing pass.
// A stalled result register stops the back end; the queue then fills and
// only then is in_ready_o dropped.
// ----------------------------------------------------------------------------
module temperature_monitor_with_hysteresis #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tmh_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tmh_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tmh_pkg::AdcW-1:0]          adc_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tmh_pkg::TempW-1:0]  temperature_o,
  output logic                              filtered_valid_o,
  output logic signed [tmh_pkg::TempW-1:0]  filtered_temperature_o,
  output logic                              unsafe_o
);
  import tmh_pkg::*;

  logic      push, full, pop, q_valid;
  tmh_item_t f_item, q_item;

  // conversion front end
  tmh_front #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .adc_count_i(adc_count_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (f_item)
  );

  // decoupling queue
  tmh_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  // averaging and hysteresis back end
  tmh_back #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .q_valid_i             (q_valid),
    .q_item_i              (q_item),
    .pop_o                 (pop),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .temperature_o         (temperature_o),
    .filtered_valid_o      (filtered_valid_o),
    .filtered_temperature_o(filtered_temperature_o),
    .unsafe_o              (unsafe_o)
  );

endmodule
